### rtl/core/frss_pkg.sv
// ----------------------------------------------------------------------------
// frss_pkg - shared definitions for the fixed record sync scanner
// Default geometry of the record, register map and reset values.
// ----------------------------------------------------------------------------
package frss_pkg;

  // Record geometry defaults
  localparam int unsigned RECORD_LEN_DEF         = 200;
  localparam int unsigned SIGNATURE_OFFSET_DEF   = 44;
  localparam int unsigned EVENT_TIME_OFFSET_DEF  = 16;
  localparam int unsigned ACCEPT_TIME_OFFSET_DEF = 22;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned STAMP_W = 48;

  // Register map: one 32-bit register per word, index in paddr[2]
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic        REG_SIGNATURE = 1'b0;

  localparam logic [BYTE_W-1:0] SIGNATURE_RESET = 8'h05;

endpackage

### rtl/core/fixed_record_sync_scanner.sv
// ----------------------------------------------------------------------------
// fixed_record_sync_scanner - byte stream scanner for fixed-length records
// Finds records by signature byte and two valid timestamps, reports offsets.
// ----------------------------------------------------------------------------
// The block takes one file byte per cycle on the input stream and keeps the
// last RecordLen bytes in a shift line. Each byte that completes a full window
// is tested once it is in the shift line: the byte at SignatureOffset must equal
// the signature register, and both six-byte swapped-BCD timestamps must decode
// to a valid date and time. A passing record gives one transfer on the output
// stream from the result register, carrying its 0-based start offset and both
// raw timestamps; the next RecordLen - 1 start positions are then skipped. A
// byte marked tlast ends the file: the fill count, skip count and byte count
// restart for the next file, and a record cut short by the end of a file is
// never reported. Throughput is one byte per cycle; the input is held off only
// while a tested byte waits behind an output transfer that the sink is not
// taking, since the single result register is the only buffer.
// Write the signature register only while no transfer is in flight.
// ----------------------------------------------------------------------------
module fixed_record_sync_scanner import frss_pkg::*; #(
  parameter int unsigned RecordLen        = RECORD_LEN_DEF,
  parameter int unsigned SignatureOffset  = SIGNATURE_OFFSET_DEF,
  parameter int unsigned EventTimeOffset  = EVENT_TIME_OFFSET_DEF,
  parameter int unsigned AcceptTimeOffset = ACCEPT_TIME_OFFSET_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Input stream
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [BYTE_W-1:0]            s_axis_tdata_i,   // [7:0] data_byte
  input  logic                         s_axis_tlast_i,   // last_of_file
  // Result stream
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [POS_W+2*STAMP_W-1:0]   m_axis_tdata_o,   // [31:0] record_position,
                                                         // [79:32] event_time_tbcd,
                                                         // [127:80] accept_time_tbcd
  // Configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [PADDR_W-1:0]           paddr,
  input  logic [PDATA_W-1:0]           pwdata,
  output logic [PDATA_W-1:0]           prdata,
  output logic                         pready
);

  localparam int unsigned CntW = $clog2(RecordLen + 1);
  localparam logic [CntW-1:0]  LenCnt  = CntW'(RecordLen);
  localparam logic [CntW-1:0]  SkipMax = CntW'(RecordLen - 1);
  localparam logic [POS_W-1:0] LenPos  = POS_W'(RecordLen);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [BYTE_W-1:0] sig_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SIGNATURE) ? PDATA_W'(sig_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_q <= SIGNATURE_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_SIGNATURE)) begin
      sig_q <= pwdata[BYTE_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Handshake and stage control
  // --------------------------------------------------------------------------
  logic chk_q, chk_d;          // a tested byte sits in the window
  logic out_vld_q, out_vld_d;
  logic chk_go, in_xfer, result_load;
  logic chk_full_q, chk_last_q;
  logic [POS_W-1:0] chk_pos_q;
  logic pass;

  // Hold the tested byte while the result register is full and not draining
  assign chk_go          = chk_q && !(out_vld_q && !m_axis_tready_i);
  assign s_axis_tready_o = !chk_q || chk_go;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  logic [CntW-1:0] skip_q, skip_d;
  assign result_load = chk_go && chk_full_q && (skip_q == '0) && pass;

  always_comb begin
    chk_d = chk_q;
    if (in_xfer) begin
      chk_d = 1'b1;
    end else if (chk_go) begin
      chk_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (result_load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  // Advance the skip count once per tested byte; end of file clears it
  always_comb begin
    skip_d = skip_q;
    if (chk_go) begin
      if (chk_last_q) begin
        skip_d = '0;
      end else if (chk_full_q) begin
        if (skip_q != '0) begin
          skip_d = skip_q - CntW'(1);
        end else if (pass) begin
          skip_d = SkipMax;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Byte counters
  // --------------------------------------------------------------------------
  logic [CntW-1:0]  fill_q, fill_d;
  logic [POS_W-1:0] seen_q, seen_d;

  always_comb begin
    fill_d = fill_q;
    seen_d = seen_q;
    if (in_xfer) begin
      if (s_axis_tlast_i) begin
        fill_d = '0;
        seen_d = '0;
      end else begin
        seen_d = seen_q + POS_W'(1);
        if (fill_q < LenCnt) begin
          fill_d = fill_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_q      <= 1'b0;
      out_vld_q  <= 1'b0;
      skip_q     <= '0;
      fill_q     <= '0;
      seen_q     <= '0;
      chk_full_q <= 1'b0;
      chk_last_q <= 1'b0;
    end else begin
      chk_q     <= chk_d;
      out_vld_q <= out_vld_d;
      skip_q    <= skip_d;
      fill_q    <= fill_d;
      seen_q    <= seen_d;
      if (in_xfer) begin
        chk_full_q <= (fill_q >= SkipMax);
        chk_last_q <= s_axis_tlast_i;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Window shift line: newest byte at the top, record start at tap 0
  // --------------------------------------------------------------------------
  logic [BYTE_W-1:0] win_q [RecordLen];

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      for (int k = 0; k < RecordLen - 1; k++) begin
        win_q[k] <= win_q[k+1];
      end
      win_q[RecordLen-1] <= s_axis_tdata_i;
      chk_pos_q          <= seen_q + POS_W'(1) - LenPos;
    end
  end

  // --------------------------------------------------------------------------
  // Record test and result register
  // --------------------------------------------------------------------------
  logic [STAMP_W-1:0] evt_tbcd, acc_tbcd;

  frss_check #(
    .RecordLen        (RecordLen),
    .SignatureOffset  (SignatureOffset),
    .EventTimeOffset  (EventTimeOffset),
    .AcceptTimeOffset (AcceptTimeOffset)
  ) u_check (
    .window_i      (win_q),
    .signature_i   (sig_q),
    .pass_o        (pass),
    .event_tbcd_o  (evt_tbcd),
    .accept_tbcd_o (acc_tbcd)
  );

  logic [POS_W+2*STAMP_W-1:0] out_data_q;

  always_ff @(posedge clk_i) begin
    if (result_load) begin
      out_data_q <= {acc_tbcd, evt_tbcd, chk_pos_q};
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

### rtl/core/frss_check.sv
// ----------------------------------------------------------------------------
// frss_check - record test on a full window
// Signature compare, swapped-BCD timestamp range checks and raw stamp pick-up.
// ----------------------------------------------------------------------------
module frss_check import frss_pkg::*; #(
  parameter int unsigned RecordLen        = RECORD_LEN_DEF,
  parameter int unsigned SignatureOffset  = SIGNATURE_OFFSET_DEF,
  parameter int unsigned EventTimeOffset  = EVENT_TIME_OFFSET_DEF,
  parameter int unsigned AcceptTimeOffset = ACCEPT_TIME_OFFSET_DEF
) (
  input  logic [BYTE_W-1:0]  window_i [RecordLen],
  input  logic [BYTE_W-1:0]  signature_i,
  output logic               pass_o,
  output logic [STAMP_W-1:0] event_tbcd_o,
  output logic [STAMP_W-1:0] accept_tbcd_o
);

  localparam int unsigned MaxA   = (SignatureOffset + 1 > RecordLen) ?
                                   SignatureOffset + 1 : RecordLen;
  localparam int unsigned MaxB   = (EventTimeOffset + 6 > MaxA) ? EventTimeOffset + 6 : MaxA;
  localparam int unsigned PadLen = (AcceptTimeOffset + 6 > MaxB) ? AcceptTimeOffset + 6 : MaxB;

  localparam logic [7:0] YearMax   = 8'd99;
  localparam logic [7:0] MonthMax  = 8'd12;
  localparam logic [7:0] DayMax    = 8'd31;
  localparam logic [7:0] HourMax   = 8'd23;
  localparam logic [7:0] MinSecMax = 8'd59;

  // Swapped BCD: low nibble is tens, high nibble is units
  function automatic logic [7:0] bcd_swap(input logic [7:0] b);
    return ({4'b0, b[3:0]} * 8'd10) + {4'b0, b[7:4]};
  endfunction

  function automatic logic stamp_ok(input logic [STAMP_W-1:0] raw);
    logic [7:0] yr, mo, dy, hr, mi, se;
    yr = bcd_swap(raw[47:40]);
    mo = bcd_swap(raw[39:32]);
    dy = bcd_swap(raw[31:24]);
    hr = bcd_swap(raw[23:16]);
    mi = bcd_swap(raw[15:8]);
    se = bcd_swap(raw[7:0]);
    return (yr <= YearMax) && (mo != 8'd0) && (mo <= MonthMax) &&
           (dy != 8'd0) && (dy <= DayMax) && (hr <= HourMax) &&
           (mi <= MinSecMax) && (se <= MinSecMax);
  endfunction

  // Bytes placed past the record read as zero
  logic [BYTE_W-1:0] pad [PadLen];

  for (genvar k = 0; k < PadLen; k++) begin : g_pad
    if (k < RecordLen) begin : g_in
      assign pad[k] = window_i[k];
    end else begin : g_out
      assign pad[k] = '0;
    end
  end

  assign event_tbcd_o  = {pad[EventTimeOffset],     pad[EventTimeOffset + 1],
                          pad[EventTimeOffset + 2], pad[EventTimeOffset + 3],
                          pad[EventTimeOffset + 4], pad[EventTimeOffset + 5]};
  assign accept_tbcd_o = {pad[AcceptTimeOffset],     pad[AcceptTimeOffset + 1],
                          pad[AcceptTimeOffset + 2], pad[AcceptTimeOffset + 3],
                          pad[AcceptTimeOffset + 4], pad[AcceptTimeOffset + 5]};

  assign pass_o = (pad[SignatureOffset] == signature_i) &&
                  stamp_ok(event_tbcd_o) && stamp_ok(accept_tbcd_o);

endmodule
